// File: rtl/core/data_watchpoint_unit_assert.svh
// assertion macros for the data watchpoint unit
`ifndef DATA_WATCHPOINT_UNIT_ASSERT_SVH
`define DATA_WATCHPOINT_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define DWU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("watchpoint unit check failed");

// next-cycle implication, disabled while reset is asserted
`define DWU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("watchpoint unit check failed");

`endif

// File: rtl/core/dwu_pkg.sv
// ----------------------------------------------------------------------------
// dwu_pkg
// shared constants, codes and the controller command type
// ----------------------------------------------------------------------------
`default_nettype none

package dwu_pkg;

  localparam int ENTRIES    = 8;
  localparam int ADDR_WIDTH = 16;

  // field widths fixed by the port list
  localparam int PORT_AW = 16;
  localparam int LEN_W   = 16;
  localparam int FLG_W   = 4;

  // stored address width, addresses taken modulo 2^ADDR_WIDTH
  localparam int AW    = (ADDR_WIDTH < PORT_AW) ? ADDR_WIDTH : PORT_AW;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // flag bit positions
  localparam int FLG_READ   = 0;
  localparam int FLG_WRITE  = 1;
  localparam int FLG_BREAK  = 2;
  localparam int FLG_SIGNAL = 3;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_WRITE  = 2'd3
  } op_t;

  typedef struct packed {
    logic             load;
    logic             scan;
    logic             apply;
    logic [IDX_W-1:0] idx;
  } dwu_cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/dwu_ctrl.sv
// ----------------------------------------------------------------------------
// dwu_ctrl
// sequencer: load a beat, scan the table one entry a cycle, then apply
// ----------------------------------------------------------------------------
`default_nettype none

module dwu_ctrl
  import dwu_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  output dwu_cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_t;

  state_t           state_r;
  logic [IDX_W-1:0] idx_r;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          idx_r <= '0;
          if (start) begin
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (idx_r == LAST_IDX) begin
            state_r <= ST_APPLY;
          end else begin
            idx_r <= idx_r + IDX_W'(1);
          end
        end
        ST_APPLY: begin
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign cmd.load  = (state_r == ST_IDLE) && start;
  assign cmd.scan  = (state_r == ST_SCAN);
  assign cmd.apply = (state_r == ST_APPLY);
  assign cmd.idx   = idx_r;

endmodule

`default_nettype wire

// File: rtl/core/dwu_dpath.sv
// ----------------------------------------------------------------------------
// dwu_dpath
// watchpoint table, per-entry scan compare and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module dwu_dpath
  import dwu_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dwu_cmd_t           cmd,
  input  wire logic [1:0]         in_operation,
  input  wire logic [PORT_AW-1:0] in_address,
  input  wire logic [LEN_W-1:0]   in_length,
  input  wire logic [FLG_W-1:0]   in_flags,
  output logic                    out_strobe,
  output logic                    out_hit,
  output logic [PORT_AW-1:0]      out_matched_start,
  output logic                    out_break_request,
  output logic                    out_signal_raise,
  output logic                    out_event_kind,
  output logic                    out_status
);

  // captured beat
  op_t              op_r;
  logic [AW-1:0]    addr_r;
  logic [LEN_W-1:0] len_r;
  logic [FLG_W-1:0] flags_r;

  // table
  logic             ent_valid_r [ENTRIES];
  logic [AW-1:0]    ent_start_r [ENTRIES];
  logic [LEN_W-1:0] ent_len_r   [ENTRIES];
  logic [FLG_W-1:0] ent_flg_r   [ENTRIES];

  // scan results
  logic             found_r;
  logic [IDX_W-1:0] found_idx_r;
  logic [FLG_W-1:0] found_flags_r;
  logic             free_found_r;
  logic [IDX_W-1:0] free_idx_r;
  logic             best_found_r;
  logic [AW-1:0]    best_start_r;
  logic [FLG_W-1:0] best_flags_r;

  // result registers
  logic               strobe_r;
  logic               hit_r;
  logic [PORT_AW-1:0] mstart_r;
  logic               brk_r;
  logic               sig_r;
  logic               kind_r;
  logic               status_r;

  // entry under scan
  logic             rd_valid;
  logic [AW-1:0]    rd_start;
  logic [LEN_W-1:0] rd_len;
  logic [FLG_W-1:0] rd_flg;
  logic [AW-1:0]    rd_diff;
  logic             rd_need;
  logic             rd_in_range;
  logic             rd_match;
  logic             is_access;
  logic [FLG_W-1:0] rm_flags;
  logic [FLG_W-1:0] or_flags;

  always_comb begin
    rd_valid    = ent_valid_r[cmd.idx];
    rd_start    = ent_start_r[cmd.idx];
    rd_len      = ent_len_r[cmd.idx];
    rd_flg      = ent_flg_r[cmd.idx];
    rd_diff     = addr_r - rd_start;
    rd_need     = (op_r == OP_WRITE) ? rd_flg[FLG_WRITE] : rd_flg[FLG_READ];
    // no wrap: address at or above start and offset below length
    rd_in_range = (addr_r >= rd_start) && (LEN_W'(rd_diff) < rd_len);
    rd_match    = rd_valid && rd_need && rd_in_range;
    is_access   = (op_r == OP_READ) || (op_r == OP_WRITE);
    rm_flags    = found_flags_r & ~flags_r;
    or_flags    = found_flags_r | flags_r;
  end

  // control state: scan bookkeeping, valid bits, strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      best_found_r <= 1'b0;
      strobe_r     <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        ent_valid_r[i] <= 1'b0;
      end
    end else begin
      strobe_r <= cmd.apply;
      if (cmd.load) begin
        found_r      <= 1'b0;
        free_found_r <= 1'b0;
        best_found_r <= 1'b0;
      end
      if (cmd.scan) begin
        if (rd_valid && (rd_start == addr_r)) begin
          found_r <= 1'b1;
        end
        if (!rd_valid && !free_found_r) begin
          free_found_r <= 1'b1;
        end
        if (rd_match && (!best_found_r || (rd_start < best_start_r))) begin
          best_found_r <= 1'b1;
        end
      end
      if (cmd.apply) begin
        if ((op_r == OP_INSERT) && !found_r && free_found_r) begin
          ent_valid_r[free_idx_r] <= 1'b1;
        end
        if ((op_r == OP_REMOVE) && found_r &&
            !rm_flags[FLG_READ] && !rm_flags[FLG_WRITE]) begin
          ent_valid_r[found_idx_r] <= 1'b0;
        end
      end
    end
  end

  // payload: beat capture, table contents, scan captures, results
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= op_t'(in_operation);
      addr_r  <= in_address[AW-1:0];
      len_r   <= in_length;
      flags_r <= in_flags;
    end
    if (cmd.scan) begin
      if (rd_valid && (rd_start == addr_r)) begin
        found_idx_r   <= cmd.idx;
        found_flags_r <= rd_flg;
      end
      if (!rd_valid && !free_found_r) begin
        free_idx_r <= cmd.idx;
      end
      if (rd_match && (!best_found_r || (rd_start < best_start_r))) begin
        best_start_r <= rd_start;
        best_flags_r <= rd_flg;
      end
    end
    if (cmd.apply) begin
      if (op_r == OP_INSERT) begin
        if (found_r) begin
          ent_flg_r[found_idx_r] <= or_flags;
        end else if (free_found_r) begin
          ent_start_r[free_idx_r] <= addr_r;
          ent_len_r[free_idx_r]   <= len_r;
          ent_flg_r[free_idx_r]   <= flags_r;
        end
      end
      if ((op_r == OP_REMOVE) && found_r) begin
        ent_flg_r[found_idx_r] <= rm_flags;
      end
      hit_r    <= is_access && best_found_r;
      mstart_r <= (is_access && best_found_r) ? PORT_AW'(best_start_r) : '0;
      brk_r    <= is_access && best_found_r && best_flags_r[FLG_BREAK];
      sig_r    <= is_access && best_found_r && best_flags_r[FLG_SIGNAL];
      kind_r   <= best_found_r && (op_r == OP_WRITE);
      status_r <= (op_r == OP_INSERT) && !found_r && !free_found_r;
    end
  end

  assign out_strobe        = strobe_r;
  assign out_hit           = hit_r;
  assign out_matched_start = mstart_r;
  assign out_break_request = brk_r;
  assign out_signal_raise  = sig_r;
  assign out_event_kind    = kind_r;
  assign out_status        = status_r;

endmodule

`default_nettype wire

// File: rtl/core/data_watchpoint_unit.sv
// ----------------------------------------------------------------------------
// data_watchpoint_unit
// data watchpoint table with insert, remove and lowest-start access matching
// ----------------------------------------------------------------------------
//
// channel   | handshake             | payload
// ----------+-----------------------+------------------------------------------
// input     | start && !busy        | in_operation, in_address, in_length,
//           |                       | in_flags
// result    | out_strobe, one cycle | out_hit, out_matched_start,
//           |                       | out_break_request, out_signal_raise,
//           |                       | out_event_kind, out_status
//
// - a beat passes through an accept cycle, a scan that compares one table
//   entry per cycle through the single scan read port, and an update cycle;
//   the result shows the cycle after the update
// - busy drops as the result appears, so the next beat is taken in that cycle
// - rst_n is synchronous active low and clears every valid bit at once;
//   entry contents are unknown until written and only read while valid
// - the receiver cannot stall: each result stands for exactly one cycle
//
`default_nettype none

`include "data_watchpoint_unit_assert.svh"

module data_watchpoint_unit
  import dwu_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input beat
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_operation,
  input  wire logic [PORT_AW-1:0] in_address,
  input  wire logic [LEN_W-1:0]   in_length,
  input  wire logic [FLG_W-1:0]   in_flags,
  // result beat
  output logic                    out_strobe,
  output logic                    out_hit,
  output logic [PORT_AW-1:0]      out_matched_start,
  output logic                    out_break_request,
  output logic                    out_signal_raise,
  output logic                    out_event_kind,
  output logic                    out_status
);

  // sequencer to datapath commands
  dwu_cmd_t cmd;

  // controller: idle, scan over entries, apply
  dwu_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // table and compare datapath
  dwu_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_operation      (in_operation),
    .in_address        (in_address),
    .in_length         (in_length),
    .in_flags          (in_flags),
    .out_strobe        (out_strobe),
    .out_hit           (out_hit),
    .out_matched_start (out_matched_start),
    .out_break_request (out_break_request),
    .out_signal_raise  (out_signal_raise),
    .out_event_kind    (out_event_kind),
    .out_status        (out_status)
  );

  // an accepted beat keeps the unit busy for the scan
  `DWU_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  // a result only shows once the sequencer is back to idle
  `DWU_ASSERT_IMP(a_strobe_idle, clk, rst_n, out_strobe, !busy)
  // a hit never comes with a dropped insert
  `DWU_ASSERT_IMP(a_hit_status, clk, rst_n, out_strobe && out_hit, !out_status)
  // without a hit the match fields are all zero
  `DWU_ASSERT_IMP(a_miss_zero, clk, rst_n, out_strobe && !out_hit,
    (out_matched_start == '0) && !out_break_request && !out_signal_raise &&
    !out_event_kind)

endmodule

`default_nettype wire
